[hw/rtl/ldmc_pkg.sv]
// Shared types, request and operation codes, and saturating helpers for the
// log-domain map composer. No dependencies.
package ldmc_pkg;

    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_COMPOSE = 2'd1;
    localparam logic [1:0] REQ_SCALE   = 2'd2;
    localparam logic [1:0] REQ_EVAL    = 2'd3;

    typedef logic [2:0] ldmc_op_t;

    localparam ldmc_op_t OP_LOAD    = 3'd0;
    localparam ldmc_op_t OP_COMP_DD = 3'd1;
    localparam ldmc_op_t OP_COMP_DN = 3'd2;
    localparam ldmc_op_t OP_COMP_ND = 3'd3;
    localparam ldmc_op_t OP_COMP_NN = 3'd4;
    localparam ldmc_op_t OP_SCALE   = 3'd5;
    localparam ldmc_op_t OP_EVAL_D  = 3'd6;
    localparam ldmc_op_t OP_EVAL_N  = 3'd7;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] operand_first;
        logic signed [31:0] operand_second;
        logic               operand_degenerate;
    } ldmc_in_t;

    typedef struct packed {
        logic signed [31:0] map_coefficient;
        logic signed [31:0] map_constant;
        logic               map_degenerate;
        logic               map_identity;
        logic signed [31:0] eval_result;
        logic               saturated;
    } ldmc_out_t;

    typedef struct packed {
        ldmc_op_t           op;
        logic signed [31:0] operand_first;
        logic signed [31:0] operand_second;
        logic               deg_after;
    } ldmc_entry_t;

    function automatic logic ovf33(input logic [32:0] v);
        return v[32] != v[31];
    endfunction

    function automatic logic [31:0] clamp33(input logic [32:0] v);
        if (v[32] != v[31]) begin
            return v[32] ? 32'h8000_0000 : 32'h7fff_ffff;
        end
        return v[31:0];
    endfunction

endpackage

[hw/rtl/log_domain_map_composer_core.sv]
// Top level of the log-domain map composer: front end, queue and back end.
// Uses ldmc_pkg, ldmc_front, ldmc_queue and ldmc_back.
//
// The block keeps one running map f(x) = a + logsum(x, b), or f(x) = a + x
// when degenerate. Each input word on the s_ channel loads a map, composes an
// inner map into the running map, adds a scale to a, or evaluates f at a
// point; each one gives exactly one result word on the m_ channel with the
// running map after the word, the evaluation result and a saturation flag.
// Each word passes from the queue through the issue, distance, table and
// result stages. One word per cycle is sustained while the result is not
// stalled, except that a compose of two non-degenerate maps holds the next
// word while it is in the distance and table stages: the new constant goes
// through the table ROM read and correction add before the next word reads it.
// A four-word queue sits behind the input, so words are still accepted while
// the result register waits on m_ready; the pipeline holds when the result
// is stalled and s_ready drops once the queue is full.
// Reset clears the map to the identity (degenerate, a = 0, b = 0) and empties
// the queue and pipeline.
module log_domain_map_composer_core
    import ldmc_pkg::*;
#(
    parameter int FRAC_BITS       = 16,
    parameter int LSE_TABLE_DEPTH = 1024
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ldmc_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output ldmc_out_t m_data
);

    logic        push;
    ldmc_entry_t push_data;
    logic        queue_full;
    logic        head_valid;
    ldmc_entry_t head_data;
    logic        head_pop;

    ldmc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    ldmc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .full       (queue_full),
        .pop        (head_pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    ldmc_back #(
        .FRAC_BITS       (FRAC_BITS),
        .LSE_TABLE_DEPTH (LSE_TABLE_DEPTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_data  (head_data),
        .head_pop   (head_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

[hw/rtl/ldmc_front.sv]
// Front end: accepts input words, tracks whether the running map is
// degenerate, and classifies each word into an operation. Uses ldmc_pkg.
module ldmc_front
    import ldmc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  ldmc_in_t    s_data,
    input  logic        queue_full,
    output logic        push,
    output ldmc_entry_t push_data
);

    logic deg_reg;
    logic deg_next;

    assign s_ready = !queue_full;
    assign push    = s_valid && s_ready;

    always_comb begin
        push_data.operand_first  = s_data.operand_first;
        push_data.operand_second = s_data.operand_second;
        push_data.op             = deg_reg ? OP_EVAL_D : OP_EVAL_N;
        deg_next                 = deg_reg;
        case (s_data.req_type)
            REQ_LOAD: begin
                push_data.op = OP_LOAD;
                deg_next     = s_data.operand_degenerate;
            end
            REQ_COMPOSE: begin
                if (deg_reg && s_data.operand_degenerate) begin
                    push_data.op = OP_COMP_DD;
                end else if (deg_reg) begin
                    push_data.op = OP_COMP_DN;
                end else if (s_data.operand_degenerate) begin
                    push_data.op = OP_COMP_ND;
                end else begin
                    push_data.op = OP_COMP_NN;
                end
                deg_next = deg_reg && s_data.operand_degenerate;
            end
            REQ_SCALE: begin
                push_data.op = OP_SCALE;
            end
            REQ_EVAL: begin
                push_data.op = deg_reg ? OP_EVAL_D : OP_EVAL_N;
            end
            default: begin
                deg_next = deg_reg;
            end
        endcase
        push_data.deg_after = deg_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deg_reg <= 1'b1;
        end else if (push) begin
            deg_reg <= deg_next;
        end
    end

endmodule

[hw/rtl/ldmc_queue.sv]
// Four-entry register queue between the front end and the back end.
// Uses ldmc_pkg for the entry type.
module ldmc_queue
    import ldmc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  ldmc_entry_t push_data,
    output logic        full,
    input  logic        pop,
    output logic        head_valid,
    output ldmc_entry_t head_data
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    ldmc_entry_t      mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign full       = count_reg == (PTR_W + 1)'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_data  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[hw/rtl/ldmc_back.sv]
// Back end: holds the running map, executes classified operations in a
// four-stage pipeline with the ln(1+e^-d) table ROM, and drives the result.
// Uses ldmc_pkg.
module ldmc_back
    import ldmc_pkg::*;
#(
    parameter int FRAC_BITS       = 16,
    parameter int LSE_TABLE_DEPTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        head_valid,
    input  ldmc_entry_t head_data,
    output logic        head_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output ldmc_out_t   m_data
);

    localparam int IDX_W  = $clog2(LSE_TABLE_DEPTH);
    localparam int SPAN_W = FRAC_BITS + 4;
    localparam int PROD_W = SPAN_W + $clog2(LSE_TABLE_DEPTH + 1);
    localparam logic [32:0] SPAN = 33'(1) << SPAN_W;
    localparam longint unsigned QONE = 64'd1 << 30;
    localparam longint unsigned LSE_STEP = (64'd16 << 30) / LSE_TABLE_DEPTH;

    typedef logic [FRAC_BITS-1:0] lse_rom_t [LSE_TABLE_DEPTH];

    // Truncating unsigned division by shift and subtract, used only while the
    // table constant is built.
    function automatic longint unsigned udiv_u64(input longint unsigned num,
                                                 input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 64'd0;
        rem = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic lse_rom_t build_lse_rom();
        lse_rom_t        rom;
        longint unsigned s;
        longint unsigned base;
        longint unsigned term;
        longint unsigned u;
        longint unsigned z;
        longint unsigned z2;
        longint unsigned p;
        longint unsigned acc;
        longint unsigned ln;
        longint unsigned kk;
        s    = LSE_STEP;
        base = QONE;
        term = QONE;
        u    = QONE;
        for (int k = 1; k <= 12; k++) begin
            kk   = 64'(k);
            term = udiv_u64((term * s) >> 30, kk);
            if ((kk & 64'd1) != 64'd0) begin
                base = base - term;
            end else begin
                base = base + term;
            end
        end
        for (int i = 0; i < LSE_TABLE_DEPTH; i++) begin
            z   = udiv_u64(u << 30, 64'd2 * QONE + u);
            z2  = (z * z) >> 30;
            p   = z;
            acc = 64'd0;
            for (int k = 0; k < 15; k++) begin
                kk  = 64'(2 * k + 1);
                acc = acc + udiv_u64(p, kk);
                p   = (p * z2) >> 30;
            end
            ln     = 64'd2 * acc;
            rom[i] = FRAC_BITS'((ln + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
            u      = (u * base + (QONE >> 1)) >> 30;
        end
        return rom;
    endfunction

    localparam lse_rom_t LSE_ROM = build_lse_rom();

    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic               deg;
        logic               sat;
        logic signed [31:0] p;
        logic signed [31:0] q;
        logic signed [31:0] x;
        logic               is_eval;
        logic               use_lse;
        logic               lse_upd;
    } st2_t;

    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic               deg;
        logic               sat;
        logic signed [31:0] hi;
        logic               in_range;
        logic signed [31:0] x;
        logic               is_eval;
        logic               use_lse;
        logic               lse_upd;
    } st3_t;

    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic               deg;
        logic               sat;
        logic signed [31:0] v;
        logic               is_eval;
    } st4_t;

    logic signed [31:0]   acc_coef_reg;
    logic signed [31:0]   acc_const_reg;
    logic                 s2_valid_reg;
    logic                 s3_valid_reg;
    logic                 s4_valid_reg;
    logic                 m_valid_reg;
    st2_t                 s2_reg;
    st2_t                 s2_next;
    st3_t                 s3_reg;
    st3_t                 s3_next;
    st4_t                 s4_reg;
    st4_t                 s4_next;
    logic [FRAC_BITS-1:0] rom_q_reg;
    ldmc_out_t            m_data_reg;
    ldmc_out_t            m_data_next;

    logic        adv;
    logic        hazard;
    logic        issue;
    logic [32:0] sum_a;
    logic [32:0] diff_b;
    logic [32:0] pq;
    logic [32:0] d_abs;
    logic [PROD_W-1:0] prod;
    logic [IDX_W-1:0]  idx;
    logic [32:0] lse_sum;
    logic [31:0] lse_val;
    logic [32:0] ev_sum;

    assign adv      = !m_valid_reg || m_ready;
    assign hazard   = (s2_valid_reg && s2_reg.lse_upd) || (s3_valid_reg && s3_reg.lse_upd);
    assign issue    = adv && head_valid && !hazard;
    assign head_pop = issue;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Issue stage: coefficient and simple constant updates, table operands.
    always_comb begin
        sum_a  = {acc_coef_reg[31], acc_coef_reg}
               + {head_data.operand_first[31], head_data.operand_first};
        diff_b = {acc_const_reg[31], acc_const_reg}
               - {head_data.operand_first[31], head_data.operand_first};
        s2_next.a       = clamp33(sum_a);
        s2_next.b       = acc_const_reg;
        s2_next.deg     = head_data.deg_after;
        s2_next.sat     = ovf33(sum_a);
        s2_next.p       = head_data.operand_first;
        s2_next.q       = acc_const_reg;
        s2_next.x       = head_data.operand_first;
        s2_next.is_eval = 1'b0;
        s2_next.use_lse = 1'b0;
        s2_next.lse_upd = 1'b0;
        case (head_data.op)
            OP_LOAD: begin
                s2_next.a   = head_data.operand_first;
                s2_next.b   = head_data.deg_after ? 32'sd0 : head_data.operand_second;
                s2_next.sat = 1'b0;
            end
            OP_COMP_DD, OP_SCALE: begin
                s2_next.b = acc_const_reg;
            end
            OP_COMP_DN: begin
                s2_next.b = head_data.operand_second;
            end
            OP_COMP_ND: begin
                s2_next.b   = clamp33(diff_b);
                s2_next.sat = ovf33(sum_a) || ovf33(diff_b);
            end
            OP_COMP_NN: begin
                s2_next.p       = head_data.operand_second;
                s2_next.q       = clamp33(diff_b);
                s2_next.sat     = ovf33(sum_a) || ovf33(diff_b);
                s2_next.use_lse = 1'b1;
                s2_next.lse_upd = 1'b1;
            end
            OP_EVAL_D: begin
                s2_next.a       = acc_coef_reg;
                s2_next.sat     = 1'b0;
                s2_next.is_eval = 1'b1;
            end
            OP_EVAL_N: begin
                s2_next.a       = acc_coef_reg;
                s2_next.sat     = 1'b0;
                s2_next.is_eval = 1'b1;
                s2_next.use_lse = 1'b1;
            end
            default: begin
                s2_next.a   = acc_coef_reg;
                s2_next.sat = 1'b0;
            end
        endcase
    end

    // Distance stage: larger operand, distance and table index.
    always_comb begin
        pq    = {s2_reg.p[31], s2_reg.p} - {s2_reg.q[31], s2_reg.q};
        d_abs = pq[32] ? (~pq + 33'd1) : pq;
        prod  = PROD_W'(d_abs[SPAN_W-1:0]) * PROD_W'(LSE_TABLE_DEPTH);
        idx   = prod[SPAN_W +: IDX_W];
        s3_next.a        = s2_reg.a;
        s3_next.b        = s2_reg.b;
        s3_next.deg      = s2_reg.deg;
        s3_next.sat      = s2_reg.sat;
        s3_next.hi       = pq[32] ? s2_reg.q : s2_reg.p;
        s3_next.in_range = d_abs < SPAN;
        s3_next.x        = s2_reg.x;
        s3_next.is_eval  = s2_reg.is_eval;
        s3_next.use_lse  = s2_reg.use_lse;
        s3_next.lse_upd  = s2_reg.lse_upd;
    end

    // Table stage: max plus correction, saturated.
    always_comb begin
        lse_sum = {s3_reg.hi[31], s3_reg.hi}
                + (s3_reg.in_range ? 33'(rom_q_reg) : 33'd0);
        lse_val = clamp33(lse_sum);
        s4_next.a       = s3_reg.a;
        s4_next.b       = s3_reg.lse_upd ? lse_val : s3_reg.b;
        s4_next.deg     = s3_reg.deg;
        s4_next.sat     = s3_reg.sat || (s3_reg.use_lse && ovf33(lse_sum));
        s4_next.v       = s3_reg.use_lse ? lse_val : s3_reg.x;
        s4_next.is_eval = s3_reg.is_eval;
    end

    // Result stage: evaluation sum and the result word.
    always_comb begin
        ev_sum = {s4_reg.a[31], s4_reg.a} + {s4_reg.v[31], s4_reg.v};
        m_data_next.map_coefficient = s4_reg.a;
        m_data_next.map_constant    = s4_reg.b;
        m_data_next.map_degenerate  = s4_reg.deg;
        m_data_next.map_identity    = s4_reg.deg && (s4_reg.a == 32'sd0);
        m_data_next.eval_result     = s4_reg.is_eval ? clamp33(ev_sum) : 32'sd0;
        m_data_next.saturated       = s4_reg.sat || (s4_reg.is_eval && ovf33(ev_sum));
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_reg     <= s2_next;
            s3_reg     <= s3_next;
            rom_q_reg  <= LSE_ROM[idx];
            s4_reg     <= s4_next;
            m_data_reg <= m_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_coef_reg  <= '0;
            acc_const_reg <= '0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= issue;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            m_valid_reg  <= s4_valid_reg;
            if (issue) begin
                acc_coef_reg  <= s2_next.a;
                acc_const_reg <= s2_next.b;
            end else if (s3_valid_reg && s3_reg.lse_upd) begin
                acc_const_reg <= lse_val;
            end
        end
    end

    a_one_table_update: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s2_valid_reg && s2_reg.lse_upd && s3_valid_reg && s3_reg.lse_upd))
        else $error("two table-based constant updates in flight");

    a_const_written_back: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && s3_valid_reg && s3_reg.lse_upd |=> acc_const_reg == s4_reg.b)
        else $error("running constant differs from the word leaving the table stage");

    a_degenerate_const_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.map_degenerate |-> m_data_reg.map_constant == 32'sd0)
        else $error("degenerate map reported with a nonzero constant");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> $stable(s4_valid_reg) && $stable(acc_coef_reg))
        else $error("pipeline moved while the result word was stalled");

endmodule
